@@ rtl/periodic_timer_table_core_defines.svh @@
// ----------------------------------------------------------------------------
// Periodic timer table: assertion macros
// Wraps concurrent checks so that synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_TABLE_CORE_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define PTT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define PTT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PTT_ASSERT_IMPL(lbl, ante, cons)
`define PTT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// Periodic timer table package
// Field widths, operation and status codes, controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

	localparam int MODE_W   = 3;
	localparam int ID_W     = 32;
	localparam int NOW_W    = 48;
	localparam int STATUS_W = 2;
	localparam int MARGIN_W = 16;

	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd1000;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ADD      = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CHANGE   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RESET    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SOON     = 3'd4;
	localparam logic [MODE_W-1:0] MODE_REMOVE   = 3'd5;
	localparam logic [MODE_W-1:0] MODE_DEADLINE = 3'd6;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

endpackage

`default_nettype wire

@@ rtl/ptt_if.sv @@
// ----------------------------------------------------------------------------
// Periodic timer table channels
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptt_req_if;
	logic                              valid;
	logic                              ready;
	logic [ptt_pkg::MODE_W-1:0]        mode;
	logic [ptt_pkg::ID_W-1:0]          entry_id;
	logic [ptt_pkg::ID_W-1:0]          interval;
	logic [ptt_pkg::NOW_W-1:0]         now_time;
	modport source (output valid, mode, entry_id, interval, now_time, input ready);
	modport sink (input valid, mode, entry_id, interval, now_time, output ready);
endinterface

interface ptt_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [ptt_pkg::STATUS_W-1:0]      status;
	logic [ptt_pkg::ID_W-1:0]          result_id;
	logic                              is_due;
	logic [ptt_pkg::NOW_W-1:0]         deadline;
	logic                              wake;
	logic                              last;
	modport source (output valid, status, result_id, is_due, deadline, wake, last,
		input ready);
	modport sink (input valid, status, result_id, is_due, deadline, wake, last,
		output ready);
endinterface

interface ptt_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [ptt_pkg::MARGIN_W-1:0]      data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/periodic_timer_table_core.sv @@
// ----------------------------------------------------------------------------
// Periodic timer table core
// Table of periodic timers held in one RAM, scanned one slot per cycle.
// ----------------------------------------------------------------------------
// Each request is handled by one pass over all ENTRIES slots of the table
// RAM. One slot is read per cycle; after the last read the read stage
// drains and the end of the pass settles, and the result is then offered.
// A deadline query also drains its minimum-compare stage before the end
// of the pass. A tick that finds N entries due spends one further pass
// per reported id to pick the lowest remaining id, and the result of a
// pass is loaded only once the result register is no longer held by the
// receiver. A new request is taken once the last result of the previous
// one sits in the output register. Slot valid bits are flip-flops cleared
// by reset; ids, intervals and last-fire times live in the RAM and need no
// clearing. Times wrap modulo 2^TIME_BITS.
`default_nettype none

`include "periodic_timer_table_core_defines.svh"

module periodic_timer_table_core #(
	parameter int ENTRIES   = 16,
	parameter int TIME_BITS = 48
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ptt_req_if.sink    req,
	ptt_rsp_if.source  rsp,
	ptt_cfg_if.sink    cfg
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int IDW = ptt_pkg::ID_W;
	localparam int WW = 2 * IDW + TIME_BITS;
	localparam int NW = ptt_pkg::NOW_W;
	localparam logic [CW-1:0] CNT_END = CW'(ENTRIES);
	localparam logic [TIME_BITS-1:0] TOP = {1'b1, {(TIME_BITS-1){1'b0}}};

	// control state
	ptt_pkg::state_t state_q;
	logic [CW-1:0] cnt_q;
	logic v_s1, v_s2;
	logic pick_q, found_q, any_q;
	logic [ENTRIES-1:0] valid_q, due_q;
	logic [IDW-1:0] next_id_q;
	logic [ptt_pkg::MARGIN_W-1:0] margin_q;
	logic rsp_valid_q;

	// payload registers
	logic [ptt_pkg::MODE_W-1:0] op_q;
	logic [IDW-1:0] id_q, ivl_q, best_id_q;
	logic [TIME_BITS-1:0] now_q, d_s2, best_key_q, best_dl_q;
	logic [IW-1:0] idx_s1, slot_q;
	logic [ptt_pkg::STATUS_W-1:0] status_q;
	logic [IDW-1:0] result_id_q;
	logic is_due_q, wake_q, last_q;
	logic [NW-1:0] deadline_q;

	// ram ports
	logic ram_we;
	logic [IW-1:0] ram_waddr;
	logic [WW-1:0] ram_wdata, ram_rdata;

	ptt_ram #(.WIDTH(WW), .DEPTH(ENTRIES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cnt_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	// read word fields
	logic [IDW-1:0] rd_id, rd_ivl;
	logic [TIME_BITS-1:0] rd_last, rd_ivl_t, margin_t, key2;
	logic [NW+TIME_BITS-1:0] now_wide, dl_wide;
	logic in_scan, accept, issue, pass_done, out_free, fin, vld1, hit1, late1;
	logic take1, take2, due_set, any_set;
	logic [ENTRIES-1:0] rest;

	assign rd_id    = ram_rdata[WW-1 -: IDW];
	assign rd_ivl   = ram_rdata[TIME_BITS+IDW-1 -: IDW];
	assign rd_last  = ram_rdata[TIME_BITS-1:0];
	assign rd_ivl_t = TIME_BITS'(rd_ivl);
	assign margin_t = TIME_BITS'(margin_q);
	assign now_wide = {{TIME_BITS{1'b0}}, req.now_time};
	assign dl_wide  = {{NW{1'b0}}, best_dl_q};
	assign key2     = (d_s2 - now_q) ^ TOP;

	assign in_scan   = (state_q == ptt_pkg::ST_SCAN);
	assign accept    = req.valid && req.ready;
	assign issue     = in_scan && (cnt_q < CNT_END);
	assign pass_done = in_scan && (cnt_q == CNT_END) && !v_s1 && !v_s2;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign fin       = pass_done && out_free;
	assign vld1      = valid_q[idx_s1];
	assign hit1      = vld1 && (rd_id == id_q);
	assign late1     = (now_q - rd_last) > rd_ivl_t;
	assign rest      = due_q & ~(ENTRIES'(1) << slot_q);

	// per-slot decisions in the read stage
	always_comb begin
		take1 = 1'b0;
		due_set = 1'b0;
		any_set = 1'b0;
		if (in_scan && v_s1) begin
			case (op_q)
				ptt_pkg::MODE_TICK: begin
					if (pick_q) begin
						take1 = due_q[idx_s1] && (!found_q || rd_id < best_id_q);
					end else begin
						any_set = vld1;
						due_set = vld1 && late1;
					end
				end
				ptt_pkg::MODE_ADD: take1 = !vld1 && !found_q;
				ptt_pkg::MODE_CHANGE, ptt_pkg::MODE_RESET, ptt_pkg::MODE_SOON:
					take1 = hit1 && !found_q;
				ptt_pkg::MODE_REMOVE: take1 = hit1 && (id_q != '0);
				default: take1 = 1'b0;
			endcase
		end
	end

	// min-key compare for deadline query
	assign take2 = v_s2 && (!found_q || key2 < best_key_q);

	// ram write-back: read stage updates, or the new entry of an add
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = ram_rdata;
		if (due_set) begin
			ram_we = 1'b1;
			ram_wdata = {rd_id, rd_ivl, rd_last + rd_ivl_t};
		end else if (take1) begin
			case (op_q)
				ptt_pkg::MODE_CHANGE: begin
					ram_we = 1'b1;
					ram_wdata = {rd_id, ivl_q, rd_last};
				end
				ptt_pkg::MODE_RESET: begin
					ram_we = 1'b1;
					ram_wdata = {rd_id, rd_ivl, now_q};
				end
				ptt_pkg::MODE_SOON: begin
					ram_we = 1'b1;
					ram_wdata = {rd_id, rd_ivl, now_q - rd_ivl_t - margin_t};
				end
				default: ram_we = 1'b0;
			endcase
		end else if (fin && op_q == ptt_pkg::MODE_ADD && found_q) begin
			ram_we = 1'b1;
			ram_waddr = slot_q;
			ram_wdata = {next_id_q, ivl_q, now_q - TIME_BITS'(ivl_q) - margin_t};
		end
	end

	// end-of-pass result
	logic emit, done, restart, r_due, r_wake, r_last;
	logic [ptt_pkg::STATUS_W-1:0] r_status;
	logic [IDW-1:0] r_id;
	logic [NW-1:0] r_dl;

	always_comb begin
		emit = 1'b1;
		done = 1'b1;
		restart = 1'b0;
		r_status = ptt_pkg::STAT_OK;
		r_id = '0;
		r_due = 1'b0;
		r_dl = '0;
		r_wake = 1'b0;
		r_last = 1'b1;
		case (op_q)
			ptt_pkg::MODE_TICK: begin
				if (!pick_q) begin
					if (due_q == '0) begin
						r_status = any_q ? ptt_pkg::STAT_OK : ptt_pkg::STAT_EMPTY;
					end else begin
						emit = 1'b0;
						done = 1'b0;
						restart = 1'b1;
					end
				end else begin
					r_id = best_id_q;
					r_due = 1'b1;
					r_last = (rest == '0);
					done = r_last;
					restart = !r_last;
				end
			end
			ptt_pkg::MODE_ADD: begin
				if (found_q) begin
					r_id = next_id_q;
					r_wake = 1'b1;
				end else begin
					r_status = ptt_pkg::STAT_FULL;
				end
			end
			ptt_pkg::MODE_CHANGE, ptt_pkg::MODE_RESET, ptt_pkg::MODE_SOON,
			ptt_pkg::MODE_REMOVE: begin
				r_status = found_q ? ptt_pkg::STAT_OK : ptt_pkg::STAT_NOTFOUND;
				r_wake = found_q && (op_q == ptt_pkg::MODE_SOON);
			end
			ptt_pkg::MODE_DEADLINE: begin
				if (found_q) begin
					r_dl = dl_wide[NW-1:0];
				end else begin
					r_status = ptt_pkg::STAT_EMPTY;
				end
			end
			default: r_status = ptt_pkg::STAT_OK;
		endcase
	end

	// controller and table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptt_pkg::ST_IDLE;
			cnt_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			pick_q <= 1'b0;
			found_q <= 1'b0;
			any_q <= 1'b0;
			valid_q <= '0;
			due_q <= '0;
			next_id_q <= IDW'(1);
			margin_q <= ptt_pkg::MARGIN_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				margin_q <= cfg.data;
			end
			// output beat: load on a finished pass that emits a result, drop once taken
			if (fin && emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			v_s1 <= issue;
			v_s2 <= in_scan && v_s1 && vld1 && (op_q == ptt_pkg::MODE_DEADLINE);
			if (issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (any_set) begin
				any_q <= 1'b1;
			end
			if (due_set) begin
				due_q[idx_s1] <= 1'b1;
			end
			if (take1 || take2) begin
				found_q <= 1'b1;
			end
			if (take1 && op_q == ptt_pkg::MODE_REMOVE) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (accept) begin
				state_q <= ptt_pkg::ST_SCAN;
				cnt_q <= '0;
				found_q <= 1'b0;
				any_q <= 1'b0;
				pick_q <= 1'b0;
				due_q <= '0;
			end
			if (fin) begin
				if (op_q == ptt_pkg::MODE_ADD && found_q) begin
					valid_q[slot_q] <= 1'b1;
					next_id_q <= (next_id_q == '1) ? IDW'(1) : next_id_q + IDW'(1);
				end
				if (op_q == ptt_pkg::MODE_TICK && pick_q) begin
					due_q <= rest;
				end
				if (done) begin
					state_q <= ptt_pkg::ST_IDLE;
				end
				if (restart) begin
					cnt_q <= '0;
					found_q <= 1'b0;
					pick_q <= 1'b1;
				end
			end
		end
	end

	// request capture, stage registers and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req.mode;
			id_q <= req.entry_id;
			ivl_q <= req.interval;
			now_q <= now_wide[TIME_BITS-1:0];
		end
		idx_s1 <= cnt_q[IW-1:0];
		d_s2 <= rd_last + rd_ivl_t;
		if (take1) begin
			slot_q <= idx_s1;
			best_id_q <= rd_id;
		end
		if (take2) begin
			best_key_q <= key2;
			best_dl_q <= d_s2;
		end
		if (fin && emit) begin
			status_q <= r_status;
			result_id_q <= r_id;
			is_due_q <= r_due;
			deadline_q <= r_dl;
			wake_q <= r_wake;
			last_q <= r_last;
		end
	end

	assign req.ready = (state_q == ptt_pkg::ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.result_id = result_id_q;
	assign rsp.is_due = is_due_q;
	assign rsp.deadline = deadline_q;
	assign rsp.wake = wake_q;
	assign rsp.last = last_q;

	// checks
	`PTT_ASSERT_IMPL(a_no_ram_write_idle, state_q == ptt_pkg::ST_IDLE, !ram_we)
	`PTT_ASSERT_NEXT(a_accept_starts_scan, accept, state_q == ptt_pkg::ST_SCAN)
	`PTT_ASSERT_IMPL(a_due_beat_ok, rsp.valid && rsp.is_due,
		rsp.status == ptt_pkg::STAT_OK && rsp.result_id != '0)

endmodule

`default_nettype wire

@@ rtl/ptt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ dv/periodic_timer_table_core_tb.sv @@
// ----------------------------------------------------------------------------
// Periodic timer table core testbench
// Drives add, change, reset, soon, remove, tick and deadline requests.
// An internal table mirrors the core and predicts every response beat.
// Each response beat is compared field by field with the oldest prediction.
// Phases with different backdate margins, a table-full sweep, response
// back-pressure and randomized traffic run in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_table_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS    = 16;
	localparam int WD_LIMIT = 20000;
	localparam logic [ptt_pkg::MODE_W-1:0] MODE_NOP = 3'd7;

	typedef struct packed {
		logic [ptt_pkg::STATUS_W-1:0] status;
		logic [ptt_pkg::ID_W-1:0]     result_id;
		logic                         is_due;
		logic [ptt_pkg::NOW_W-1:0]    deadline;
		logic                         wake;
		logic                         last;
	} timer_rsp_t;

	logic clk;
	logic arst_n;

	ptt_req_if req ();
	ptt_rsp_if rsp ();
	ptt_cfg_if cfg ();

	periodic_timer_table_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// mirror of the timer table
	logic                         tbl_valid [SLOTS];
	logic [ptt_pkg::ID_W-1:0]     tbl_id    [SLOTS];
	logic [ptt_pkg::ID_W-1:0]     tbl_ivl   [SLOTS];
	logic [ptt_pkg::NOW_W-1:0]    tbl_last  [SLOTS];
	logic [ptt_pkg::ID_W-1:0]     id_counter;
	logic [ptt_pkg::MARGIN_W-1:0] margin;

	timer_rsp_t rsp_pending [$];
	int         errors = 0;
	int         idle_cycles;
	logic       rsp_hold;
	logic       hold_done;
	logic       no_stall;
	logic [ptt_pkg::NOW_W-1:0] cur_time;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report(input string what, input logic [ptt_pkg::NOW_W-1:0] got,
		input logic [ptt_pkg::NOW_W-1:0] want);
		errors++;
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
	endtask

	function automatic void push_rsp(input logic [ptt_pkg::STATUS_W-1:0] st,
		input logic [ptt_pkg::ID_W-1:0] id, input logic due,
		input logic [ptt_pkg::NOW_W-1:0] dl, input logic wk, input logic lst);
		timer_rsp_t r;
		r.status = st; r.result_id = id; r.is_due = due;
		r.deadline = dl; r.wake = wk; r.last = lst;
		rsp_pending = {rsp_pending, r};
	endfunction

	function automatic int lookup_slot(input logic [ptt_pkg::ID_W-1:0] id);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_valid[i] && tbl_id[i] == id)
				return i;
		return -1;
	endfunction

	// predict the response beats of one accepted request
	function automatic void predict_timer(input logic [ptt_pkg::MODE_W-1:0] mode,
		input logic [ptt_pkg::ID_W-1:0] id, input logic [ptt_pkg::ID_W-1:0] ivl,
		input logic [ptt_pkg::NOW_W-1:0] now);
		logic                      due [SLOTS];
		logic                      any;
		logic                      hit;
		int                        cnt;
		int                        best;
		int                        s;
		logic [ptt_pkg::NOW_W-1:0] d;
		logic [ptt_pkg::NOW_W-1:0] key;
		logic [ptt_pkg::NOW_W-1:0] best_key;
		logic [ptt_pkg::NOW_W-1:0] best_due;
		any = 1'b0; hit = 1'b0; cnt = 0; best = -1;
		best_key = '0; best_due = '0;
		case (mode)
			ptt_pkg::MODE_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					due[i] = 1'b0;
					if (tbl_valid[i]) begin
						any = 1'b1;
						if (ptt_pkg::NOW_W'(now - tbl_last[i]) > {16'd0, tbl_ivl[i]}) begin
							tbl_last[i] = tbl_last[i] + {16'd0, tbl_ivl[i]};
							due[i] = 1'b1;
							cnt++;
						end
					end
				end
				if (cnt == 0)
					push_rsp(any ? ptt_pkg::STAT_OK : ptt_pkg::STAT_EMPTY, '0, 1'b0, '0,
						1'b0, 1'b1);
				for (int k = 0; k < cnt; k++) begin
					best = -1;
					for (int i = 0; i < SLOTS; i++)
						if (due[i] && (best < 0 || tbl_id[i] < tbl_id[best]))
							best = i;
					due[best] = 1'b0;
					push_rsp(ptt_pkg::STAT_OK, tbl_id[best], 1'b1, '0, 1'b0, k == cnt - 1);
				end
			end
			ptt_pkg::MODE_ADD: begin
				s = -1;
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!tbl_valid[i])
						s = i;
				if (s < 0) begin
					push_rsp(ptt_pkg::STAT_FULL, '0, 1'b0, '0, 1'b0, 1'b1);
				end else begin
					tbl_valid[s] = 1'b1;
					tbl_id[s] = id_counter;
					tbl_ivl[s] = ivl;
					tbl_last[s] = now - {16'd0, ivl} - {32'd0, margin};
					id_counter = (id_counter == '1) ? ptt_pkg::ID_W'(1)
						: id_counter + ptt_pkg::ID_W'(1);
					push_rsp(ptt_pkg::STAT_OK, tbl_id[s], 1'b0, '0, 1'b1, 1'b1);
				end
			end
			ptt_pkg::MODE_CHANGE, ptt_pkg::MODE_RESET, ptt_pkg::MODE_SOON: begin
				s = lookup_slot(id);
				if (s < 0) begin
					push_rsp(ptt_pkg::STAT_NOTFOUND, '0, 1'b0, '0, 1'b0, 1'b1);
				end else begin
					if (mode == ptt_pkg::MODE_CHANGE)
						tbl_ivl[s] = ivl;
					else if (mode == ptt_pkg::MODE_RESET)
						tbl_last[s] = now;
					else
						tbl_last[s] = now - {16'd0, tbl_ivl[s]} - {32'd0, margin};
					push_rsp(ptt_pkg::STAT_OK, '0, 1'b0, '0, mode == ptt_pkg::MODE_SOON,
						1'b1);
				end
			end
			ptt_pkg::MODE_REMOVE: begin
				for (int i = 0; i < SLOTS; i++)
					if (tbl_valid[i] && tbl_id[i] == id && id != 0) begin
						tbl_valid[i] = 1'b0;
						hit = 1'b1;
					end
				push_rsp(hit ? ptt_pkg::STAT_OK : ptt_pkg::STAT_NOTFOUND, '0, 1'b0, '0,
					1'b0, 1'b1);
			end
			ptt_pkg::MODE_DEADLINE: begin
				for (int i = 0; i < SLOTS; i++)
					if (tbl_valid[i]) begin
						d = tbl_last[i] + {16'd0, tbl_ivl[i]};
						key = (d - now) ^ {1'b1, {(ptt_pkg::NOW_W-1){1'b0}}};
						if (!any || key < best_key) begin
							best_key = key;
							best_due = d;
							any = 1'b1;
						end
					end
				if (any)
					push_rsp(ptt_pkg::STAT_OK, '0, 1'b0, best_due, 1'b0, 1'b1);
				else
					push_rsp(ptt_pkg::STAT_EMPTY, '0, 1'b0, '0, 1'b0, 1'b1);
			end
			default: push_rsp(ptt_pkg::STAT_OK, '0, 1'b0, '0, 1'b0, 1'b1);
		endcase
	endfunction

	// send one request beat, called at a falling edge
	task automatic send_item(input logic [ptt_pkg::MODE_W-1:0] mode,
		input logic [ptt_pkg::ID_W-1:0] id, input logic [ptt_pkg::ID_W-1:0] ivl,
		input logic [ptt_pkg::NOW_W-1:0] now);
		if (!no_stall && $urandom_range(0, 99) < 13) begin
			req.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req.valid = 1'b1;
		req.mode = mode;
		req.entry_id = id;
		req.interval = ivl;
		req.now_time = now;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		predict_timer(mode, id, ivl, now);
		@(negedge clk);
		req.valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (rsp_pending.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_margin(input logic [ptt_pkg::MARGIN_W-1:0] value);
		wait_drained();
		cfg.valid = 1'b1;
		cfg.data = value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		margin = value;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	function automatic logic [ptt_pkg::ID_W-1:0] pick_id();
		int live [$];
		for (int i = 0; i < SLOTS; i++)
			if (tbl_valid[i])
				live = {live, i};
		if (live.size() != 0 && $urandom_range(0, 99) < 80)
			return tbl_id[live[$urandom_range(0, live.size() - 1)]];
		return ($urandom_range(0, 3) == 0) ? '0 : ptt_pkg::ID_W'($urandom);
	endfunction

	function automatic logic [ptt_pkg::ID_W-1:0] pick_interval();
		return ($urandom_range(0, 99) < 80) ? ptt_pkg::ID_W'($urandom_range(0, 4000))
			: $urandom;
	endfunction

	function automatic void advance_time();
		if ($urandom_range(0, 99) < 5)
			cur_time = {16'($urandom), 32'($urandom)};
		else
			cur_time = cur_time + ptt_pkg::NOW_W'($urandom_range(0, 3000));
	endfunction

	task automatic random_item();
		int roll;
		advance_time();
		roll = $urandom_range(0, 99);
		if (roll < 30)
			send_item(ptt_pkg::MODE_TICK, $urandom, $urandom, cur_time);
		else if (roll < 50)
			send_item(ptt_pkg::MODE_ADD, $urandom, pick_interval(), cur_time);
		else if (roll < 58)
			send_item(ptt_pkg::MODE_CHANGE, pick_id(), pick_interval(), cur_time);
		else if (roll < 66)
			send_item(ptt_pkg::MODE_RESET, pick_id(), $urandom, cur_time);
		else if (roll < 74)
			send_item(ptt_pkg::MODE_SOON, pick_id(), $urandom, cur_time);
		else if (roll < 86)
			send_item(ptt_pkg::MODE_REMOVE, pick_id(), $urandom, cur_time);
		else if (roll < 98)
			send_item(ptt_pkg::MODE_DEADLINE, $urandom, $urandom, cur_time);
		else
			send_item(MODE_NOP, $urandom, $urandom, cur_time);
	endtask

	// extremes of the fields and every operation
	task automatic test_directed();
		logic [ptt_pkg::NOW_W-1:0] tmax;
		tmax = '1;
		send_item(ptt_pkg::MODE_TICK, '0, '0, '0);
		send_item(ptt_pkg::MODE_DEADLINE, '0, '0, '0);
		send_item(ptt_pkg::MODE_REMOVE, '0, '0, '0);
		send_item(ptt_pkg::MODE_CHANGE, '1, '1, tmax);
		send_item(ptt_pkg::MODE_ADD, '0, '0, '0);
		send_item(ptt_pkg::MODE_ADD, '1, '1, tmax);
		send_item(ptt_pkg::MODE_ADD, '0, ptt_pkg::ID_W'(100), ptt_pkg::NOW_W'(5));
		send_item(ptt_pkg::MODE_DEADLINE, '0, '0, ptt_pkg::NOW_W'(5));
		send_item(ptt_pkg::MODE_TICK, '0, '0, ptt_pkg::NOW_W'(5));
		send_item(ptt_pkg::MODE_TICK, '0, '0, ptt_pkg::NOW_W'(6));
		send_item(ptt_pkg::MODE_CHANGE, ptt_pkg::ID_W'(3), ptt_pkg::ID_W'(7),
			ptt_pkg::NOW_W'(6));
		send_item(ptt_pkg::MODE_RESET, ptt_pkg::ID_W'(3), '0, ptt_pkg::NOW_W'(10));
		send_item(ptt_pkg::MODE_TICK, '0, '0, ptt_pkg::NOW_W'(17));
		send_item(ptt_pkg::MODE_TICK, '0, '0, ptt_pkg::NOW_W'(18));
		send_item(ptt_pkg::MODE_SOON, ptt_pkg::ID_W'(2), '0, ptt_pkg::NOW_W'(20));
		send_item(ptt_pkg::MODE_DEADLINE, '0, '0, tmax);
		send_item(ptt_pkg::MODE_RESET, '0, '0, '0);
		send_item(ptt_pkg::MODE_SOON, ptt_pkg::ID_W'(99), '0, '0);
		send_item(ptt_pkg::MODE_REMOVE, ptt_pkg::ID_W'(2), '0, ptt_pkg::NOW_W'(30));
		send_item(ptt_pkg::MODE_REMOVE, ptt_pkg::ID_W'(2), '0, ptt_pkg::NOW_W'(30));
		send_item(MODE_NOP, '1, '1, tmax);
		send_item(ptt_pkg::MODE_TICK, '1, '1, {1'b1, 47'd0});
		cur_time = ptt_pkg::NOW_W'(40);
	endtask

	// fill every slot, overflow, then fire all at once
	task automatic test_fill();
		for (int i = 0; i < SLOTS + 1; i++)
			send_item(ptt_pkg::MODE_ADD, '0, ptt_pkg::ID_W'($urandom_range(0, 50)),
				cur_time);
		cur_time = cur_time + ptt_pkg::NOW_W'(100);
		send_item(ptt_pkg::MODE_TICK, '0, '0, cur_time);
		send_item(ptt_pkg::MODE_DEADLINE, '0, '0, cur_time);
	endtask

	// response side held off while requests keep coming
	task automatic test_backpressure();
		rsp_hold = 1'b1;
		for (int i = 0; i < 12; i++)
			random_item();
		wait_drained();
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++) begin
			random_item();
			if (i == n / 3)
				no_stall = 1'b1;
			if (i == n / 2)
				no_stall = 1'b0;
		end
	endtask

	// receiver: random stalls plus one long counted hold-off
	initial begin
		rsp.ready = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold && !hold_done) begin
				rsp.ready = 1'b0;
				repeat (300) @(negedge clk);
				hold_done = 1'b1;
			end
			rsp.ready = no_stall || ($urandom_range(0, 99) >= 13);
		end
	end

	// response checker
	initial begin
		timer_rsp_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready) begin
				if (rsp_pending.size() == 0) begin
					report("unexpected beat", ptt_pkg::NOW_W'(rsp.result_id), '0);
				end else begin
					want = rsp_pending[0];
					rsp_pending.delete(0);
					if (rsp.status !== want.status)
						report("status", ptt_pkg::NOW_W'(rsp.status),
							ptt_pkg::NOW_W'(want.status));
					if (rsp.result_id !== want.result_id)
						report("result_id", ptt_pkg::NOW_W'(rsp.result_id),
							ptt_pkg::NOW_W'(want.result_id));
					if (rsp.is_due !== want.is_due)
						report("is_due", ptt_pkg::NOW_W'(rsp.is_due),
							ptt_pkg::NOW_W'(want.is_due));
					if (rsp.deadline !== want.deadline)
						report("deadline", rsp.deadline, want.deadline);
					if (rsp.wake !== want.wake)
						report("wake", ptt_pkg::NOW_W'(rsp.wake), ptt_pkg::NOW_W'(want.wake));
					if (rsp.last !== want.last)
						report("last", ptt_pkg::NOW_W'(rsp.last), ptt_pkg::NOW_W'(want.last));
				end
			end
		end
	end

	// watchdog on cycles without any beat
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)
				|| (cfg.valid && cfg.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WD_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// main sequence
	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0; req.mode = '0; req.entry_id = '0;
		req.interval = '0; req.now_time = '0;
		cfg.valid = 1'b0; cfg.data = '0;
		rsp_hold = 1'b0; no_stall = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_valid[i] = 1'b0; tbl_id[i] = '0; tbl_ivl[i] = '0; tbl_last[i] = '0;
		end
		id_counter = ptt_pkg::ID_W'(1);
		margin = ptt_pkg::MARGIN_RESET;
		cur_time = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_fill();
		write_margin('0);
		test_random(60);
		write_margin('1);
		test_backpressure();
		test_random(80);
		write_margin(ptt_pkg::MARGIN_W'($urandom));
		test_random(100);
		write_margin(ptt_pkg::MARGIN_RESET);
		test_random(30);
		wait_drained();
		repeat (400) @(negedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
